/* sv/fmf_pkg.sv */
// ----------------------------------------------------------------------------
// fmf_pkg
// Shared codes and constants of the FIX message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package fmf_pkg;

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EQ_BYTE  = 8'h3D;
	localparam logic [7:0] DIGIT_LO = 8'h30;
	localparam logic [7:0] DIGIT_HI = 8'h39;

	localparam int unsigned EVENT_W = 3;
	localparam int unsigned ERROR_W = 3;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE      = 3'd0,
		EV_VALUE     = 3'd1,
		EV_FIELD_END = 3'd2,
		EV_COMPLETE  = 3'd3,
		EV_ERROR     = 3'd4
	} event_t;

	typedef enum logic [ERROR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_FIRST_TAG = 3'd1,
		ERR_SECOND_TAG = 3'd2,
		ERR_TRAILER   = 3'd3,
		ERR_BODY_LEN  = 3'd4
	} error_t;

	// where the framer stands within one message
	typedef enum logic [3:0] {
		PH_TAG8  = 4'b0001,
		PH_TAG9  = 4'b0010,
		PH_BODY  = 4'b0100,
		PH_TAG10 = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

/* sv/fmf_in_if.sv */
// ----------------------------------------------------------------------------
// fmf_in_if
// Byte channel into the framer: one stream byte and a start flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;

	modport source (output valid, output data_byte, output start_req, input ready);
	modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

/* sv/fmf_out_if.sv */
// ----------------------------------------------------------------------------
// fmf_out_if
// Result channel out of the framer: one event word per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmf_out_if #(
	parameter int unsigned TAG_WIDTH = 20,
	parameter int unsigned LEN_WIDTH = 16
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           event_res;
	logic [TAG_WIDTH-1:0] field_tag;
	logic [7:0]           value_byte;
	logic [LEN_WIDTH-1:0] message_length;
	logic [2:0]           error_code;

	modport source (output valid, output event_res, output field_tag, output value_byte,
		output message_length, output error_code, input ready);
	modport sink   (input valid, input event_res, input field_tag, input value_byte,
		input message_length, input error_code, output ready);
endinterface

`default_nettype wire

/* sv/fix_message_framer_unit.sv */
// ----------------------------------------------------------------------------
// fix_message_framer_unit
// Streaming framer for FIX tag=value messages, one byte per word.
// ----------------------------------------------------------------------------
// Every accepted byte produces exactly one result word, registered and shown
// in the cycle after the byte is taken. A byte can be taken every cycle: the
// framer state is updated at acceptance by a single level of logic, and rx is
// ready whenever the output register is empty or is being drained in the same
// cycle, so the sustained rate is one byte per clock as long as tx takes a
// word per clock. The header must be tag 8 then tag 9 (body length), and the
// first field end at which the body count has reached that length must be
// followed by tag 10; its SOH completes the message with the total length.
// Errors and completions return the framer to its reset state; start_req
// abandons a partial message and treats its byte as the first of a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module fix_message_framer_unit
	import fmf_pkg::*;
#(
	parameter int unsigned LEN_WIDTH = 16,
	parameter int unsigned TAG_WIDTH = 20
) (
	input  wire       clk,
	input  wire       arst_n,
	fmf_in_if.sink    rx,
	fmf_out_if.source tx
);

	localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};
	localparam logic [TAG_WIDTH-1:0] TAG_MAX = {TAG_WIDTH{1'b1}};
	localparam logic [TAG_WIDTH-1:0] TAG_8   = TAG_WIDTH'(8);
	localparam logic [TAG_WIDTH-1:0] TAG_9   = TAG_WIDTH'(9);
	localparam logic [TAG_WIDTH-1:0] TAG_10  = TAG_WIDTH'(10);

	// framer state
	phase_t               phase_q;
	logic                 in_value_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic                 dig_end_q;
	logic [LEN_WIDTH-1:0] blen_q;
	logic [LEN_WIDTH-1:0] bcnt_q;
	logic [LEN_WIDTH-1:0] byte_cnt_q;

	// output register
	logic                 res_valid_q;
	event_t               res_event_q;
	logic [TAG_WIDTH-1:0] res_tag_q;
	logic [7:0]           res_byte_q;
	logic [LEN_WIDTH-1:0] res_len_q;
	error_t               res_err_q;

	// next state and result
	phase_t               nx_phase;
	logic                 nx_in_value;
	logic [TAG_WIDTH-1:0] nx_tag;
	logic                 nx_dig_end;
	logic [LEN_WIDTH-1:0] nx_blen;
	logic [LEN_WIDTH-1:0] nx_bcnt;
	logic [LEN_WIDTH-1:0] nx_byte_cnt;
	event_t               ev;
	logic [TAG_WIDTH-1:0] tag_out;
	logic [7:0]           vb;
	logic [LEN_WIDTH-1:0] ml;
	error_t               err;

	logic accept;
	logic drain;

	assign drain    = tx.ready | ~res_valid_q;
	assign rx.ready = drain;
	assign accept   = rx.valid & drain;

	always_comb begin
		phase_t               cur_phase;
		logic                 cur_in_value;
		logic [TAG_WIDTH-1:0] cur_tag;
		logic                 cur_dig_end;
		logic [LEN_WIDTH-1:0] cur_blen;
		logic [LEN_WIDTH-1:0] cur_bcnt;
		logic [LEN_WIDTH-1:0] cur_byte_cnt;
		logic [7:0]           b;
		logic                 is_digit;
		logic [3:0]           d;
		logic [TAG_WIDTH+3:0] tag_mul;
		logic [LEN_WIDTH+3:0] len_mul;
		logic                 wipe;

		b        = rx.data_byte;
		is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
		d        = b[3:0];

		// start_req discards the partial message before this byte
		if (rx.start_req) begin
			cur_phase    = PH_TAG8;
			cur_in_value = 1'b0;
			cur_tag      = '0;
			cur_dig_end  = 1'b0;
			cur_blen     = '0;
			cur_bcnt     = '0;
			cur_byte_cnt = '0;
		end else begin
			cur_phase    = phase_q;
			cur_in_value = in_value_q;
			cur_tag      = tag_q;
			cur_dig_end  = dig_end_q;
			cur_blen     = blen_q;
			cur_bcnt     = bcnt_q;
			cur_byte_cnt = byte_cnt_q;
		end

		tag_mul = ({4'b0, cur_tag} << 3) + ({4'b0, cur_tag} << 1) + (TAG_WIDTH+4)'(d);
		len_mul = ({4'b0, cur_blen} << 3) + ({4'b0, cur_blen} << 1) + (LEN_WIDTH+4)'(d);

		nx_phase    = cur_phase;
		nx_in_value = cur_in_value;
		nx_tag      = cur_tag;
		nx_dig_end  = cur_dig_end;
		nx_blen     = cur_blen;
		nx_byte_cnt = (cur_byte_cnt == LEN_MAX) ? LEN_MAX : cur_byte_cnt + 1'b1;
		nx_bcnt     = cur_bcnt;
		if (cur_phase == PH_BODY && cur_bcnt != LEN_MAX) begin
			nx_bcnt = cur_bcnt + 1'b1;
		end

		ev      = EV_NONE;
		err     = ERR_NONE;
		vb      = '0;
		ml      = '0;
		tag_out = cur_tag;
		wipe    = 1'b0;

		if (!cur_in_value) begin
			if (b == EQ_BYTE) begin
				nx_in_value = 1'b1;
				nx_dig_end  = 1'b0;
				if (cur_phase == PH_TAG8 && cur_tag != TAG_8) begin
					err = ERR_FIRST_TAG;
				end else if (cur_phase == PH_TAG9 && cur_tag != TAG_9) begin
					err = ERR_SECOND_TAG;
				end else if (cur_phase == PH_TAG10 && cur_tag != TAG_10) begin
					err = ERR_TRAILER;
				end
				if (cur_phase == PH_TAG9) begin
					nx_blen = '0;
				end
			end else if (is_digit && !cur_dig_end) begin
				nx_tag  = (tag_mul[TAG_WIDTH+3:TAG_WIDTH] != 4'b0) ?
					TAG_MAX : tag_mul[TAG_WIDTH-1:0];
				tag_out = nx_tag;
			end else begin
				nx_dig_end = 1'b1;
			end
		end else if (b == SOH_BYTE) begin
			if (cur_phase == PH_TAG10) begin
				ev   = EV_COMPLETE;
				ml   = nx_byte_cnt;
				wipe = 1'b1;
			end else begin
				ev = EV_FIELD_END;
				case (cur_phase)
					PH_TAG8: nx_phase = PH_TAG9;
					PH_TAG9: nx_phase = (cur_blen == '0) ? PH_TAG10 : PH_BODY;
					PH_BODY: begin
						if (nx_bcnt >= cur_blen) begin
							nx_phase = PH_TAG10;
						end
					end
					default: nx_phase = cur_phase;
				endcase
				nx_in_value = 1'b0;
				nx_tag      = '0;
				nx_dig_end  = 1'b0;
			end
		end else begin
			ev = EV_VALUE;
			vb = b;
			if (cur_phase == PH_TAG9) begin
				if (is_digit && !cur_dig_end) begin
					if (len_mul[LEN_WIDTH+3:LEN_WIDTH] != 4'b0) begin
						err = ERR_BODY_LEN;
					end else begin
						nx_blen = len_mul[LEN_WIDTH-1:0];
					end
				end else begin
					nx_dig_end = 1'b1;
				end
			end
		end

		if (err != ERR_NONE) begin
			ev   = EV_ERROR;
			vb   = '0;
			ml   = '0;
			wipe = 1'b1;
		end

		if (wipe) begin
			nx_phase    = PH_TAG8;
			nx_in_value = 1'b0;
			nx_tag      = '0;
			nx_dig_end  = 1'b0;
			nx_blen     = '0;
			nx_bcnt     = '0;
			nx_byte_cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG8;
			in_value_q <= 1'b0;
			tag_q      <= '0;
			dig_end_q  <= 1'b0;
			blen_q     <= '0;
			bcnt_q     <= '0;
			byte_cnt_q <= '0;
		end else if (accept) begin
			phase_q    <= nx_phase;
			in_value_q <= nx_in_value;
			tag_q      <= nx_tag;
			dig_end_q  <= nx_dig_end;
			blen_q     <= nx_blen;
			bcnt_q     <= nx_bcnt;
			byte_cnt_q <= nx_byte_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drain) begin
			res_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_event_q <= ev;
			res_tag_q   <= tag_out;
			res_byte_q  <= vb;
			res_len_q   <= ml;
			res_err_q   <= err;
		end
	end

	assign tx.valid          = res_valid_q;
	assign tx.event_res      = res_event_q;
	assign tx.field_tag      = res_tag_q;
	assign tx.value_byte     = res_byte_q;
	assign tx.message_length = res_len_q;
	assign tx.error_code     = res_err_q;

endmodule

`default_nettype wire
